@@ hw/rtl/lgap_pkg.sv @@
// ----------------------------------------------------------------------------
// lgap_pkg: shared types and constants for the longest gap insert core
// Table geometry, status codes and the scan unit control struct.
// ----------------------------------------------------------------------------
package lgap_pkg;

    // table geometry
    localparam int MAX_POINTS = 256;
    localparam int PTR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = PTR_W + 1;
    localparam int DATA_W     = 32;
    localparam int STAT_W     = 2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_OUT_RANGE = 2'd2;

    // control for the gap accumulator
    typedef struct packed {
        logic clear;  // start a fresh scan from the near end
        logic step;   // fold one point into the running maximum
    } t_scan_ctl;

endpackage

@@ hw/rtl/lgap_ram.sv @@
// ----------------------------------------------------------------------------
// lgap_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lgap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lgap_scan.sv @@
// ----------------------------------------------------------------------------
// lgap_scan: running longest gap accumulator
// Takes the sorted points one per step and keeps the last point and best gap.
// ----------------------------------------------------------------------------
module lgap_scan (
    input  logic                         i_clk,
    input  lgap_pkg::t_scan_ctl          i_ctl,
    input  logic [lgap_pkg::DATA_W-1:0]  i_point,
    output logic [lgap_pkg::DATA_W-1:0]  o_best
);

    import lgap_pkg::*;

    logic [DATA_W-1:0] r_prev;
    logic [DATA_W-1:0] r_best;
    logic [DATA_W-1:0] n_prev;
    logic [DATA_W-1:0] n_best;
    logic [DATA_W-1:0] gap;

    // a point not beyond the previous one adds a zero gap
    always_comb begin
        gap    = i_point - r_prev;
        n_prev = r_prev;
        n_best = r_best;
        if (i_ctl.clear) begin
            n_prev = '0;
            n_best = '0;
        end else if (i_ctl.step && (i_point > r_prev)) begin
            n_prev = i_point;
            if (gap > r_best) begin
                n_best = gap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_best <= n_best;
    end

    assign o_best = r_best;

endmodule

@@ hw/rtl/longest_gap_after_point_insert_core.sv @@
// ----------------------------------------------------------------------------
// longest_gap_after_point_insert_core: sorted cut point table, longest gap
// Inserts a point into a sorted table in RAM and rescans for the longest gap.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : i_in_valid / o_in_ready, one position per beat.
//   out channel : o_out_valid / i_out_ready, one longest_gap and status per
//                 input beat, in order.
//   cfg channel : i_cfg_valid / o_cfg_ready writes the line length; write it
//                 only while no item is in flight.
// Timing: one item at a time. The insert walks down from the top of the
//   table through the single-port-read RAM, one entry per cycle, moving
//   larger points up one slot; then the whole table is read once more, one
//   entry per cycle, to find the longest gap. The result enters the output
//   register and the input reopens in the same cycle. A rejected item
//   skips the walk and goes straight to the rescan.
// Reset: clears the point count, the length goes to all ones and the output
//   register empties. The RAM itself is not cleared; only entries below the
//   count are ever read.
// Stall: the finished result sits in an output register; a new item is taken
//   while it waits, and that next result holds until the register frees.
// ----------------------------------------------------------------------------
module longest_gap_after_point_insert_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lgap_pkg::DATA_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lgap_pkg::DATA_W-1:0]  i_position,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lgap_pkg::DATA_W-1:0]  o_longest_gap,
    output logic [lgap_pkg::STAT_W-1:0]  o_status
);

    import lgap_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_SCAN,
        S_TAIL,
        S_DONE
    } t_state;

    t_state              r_state,   n_state;
    logic [DATA_W-1:0]   r_len,     n_len;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [DATA_W-1:0]   r_pos,     n_pos;
    logic [PTR_W-1:0]    r_idx,     n_idx;
    logic [CNT_W-1:0]    r_sidx,    n_sidx;
    logic                r_dv,      n_dv;
    logic [STAT_W-1:0]   r_status,  n_status;
    logic                r_out_vld, n_out_vld;
    logic [DATA_W-1:0]   r_out_gap, n_out_gap;
    logic [STAT_W-1:0]   r_out_st,  n_out_st;

    logic                in_acc;
    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [PTR_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    t_scan_ctl           scan_ctl;
    logic [DATA_W-1:0]   scan_point;
    logic [DATA_W-1:0]   scan_best;

    // point table
    lgap_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // gap accumulator
    lgap_scan u_scan (
        .i_clk   (i_clk),
        .i_ctl   (scan_ctl),
        .i_point (scan_point),
        .o_best  (scan_best)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;

    // sequencer; reads walk downward while writes land one slot higher,
    // so a read never meets a pending write to the same entry
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_count   = r_count;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_sidx    = r_sidx;
        n_dv      = r_dv;
        n_status  = r_status;
        n_out_vld = r_out_vld;
        n_out_gap = r_out_gap;
        n_out_st  = r_out_st;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_pos;
        ram_re    = 1'b0;
        ram_raddr = '0;
        scan_ctl  = '{clear: 1'b0, step: 1'b0};
        scan_point = ram_rdata;

        if (i_cfg_valid) begin
            n_len = i_cfg_data;
        end

        // output register drains independently
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_pos          = i_position;
                    n_sidx         = '0;
                    n_dv           = 1'b0;
                    scan_ctl.clear = 1'b1;
                    n_state        = S_SCAN;
                    if ((i_position == '0) || (i_position >= r_len)) begin
                        n_status = ST_OUT_RANGE;
                    end else if (r_count >= CNT_W'(MAX_POINTS)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_INSERTED;
                        n_count  = r_count + 1'b1;
                        if (r_count == '0) begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = i_position;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = PTR_W'(r_count - 1'b1);
                            n_idx     = PTR_W'(r_count - 1'b1);
                            n_state   = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx + 1'b1;
                if (ram_rdata > r_pos) begin
                    ram_wdata = ram_rdata;
                    if (r_idx == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx - 1'b1;
                        n_idx     = r_idx - 1'b1;
                    end
                end else begin
                    ram_wdata = r_pos;
                    n_state   = S_SCAN;
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_pos;
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                if (r_sidx < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_sidx[PTR_W-1:0];
                    n_sidx    = r_sidx + 1'b1;
                    n_dv      = 1'b1;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    scan_ctl.step = 1'b1;
                end
                if ((r_sidx == r_count) && !r_dv) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                // far end closes the last gap
                scan_ctl.step = 1'b1;
                scan_point    = r_len;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld = 1'b1;
                    n_out_gap = scan_best;
                    n_out_st  = r_status;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '1;
            r_count   <= '0;
            r_dv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_count   <= n_count;
            r_dv      <= n_dv;
            r_out_vld <= n_out_vld;
        end
        r_pos     <= n_pos;
        r_idx     <= n_idx;
        r_sidx    <= n_sidx;
        r_status  <= n_status;
        r_out_gap <= n_out_gap;
        r_out_st  <= n_out_st;
    end

    assign o_out_valid   = r_out_vld;
    assign o_longest_gap = r_out_gap;
    assign o_status      = r_out_st;

endmodule

@@ hw/rtl/lgap_checker.sv @@
// ----------------------------------------------------------------------------
// lgap_checker: port-level checks for the longest gap insert core
// Watches the top level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module lgap_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_cfg_ready,
    input  logic                         i_in_valid,
    input  logic                         o_in_ready,
    input  logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  logic [lgap_pkg::DATA_W-1:0]  o_longest_gap,
    input  logic [lgap_pkg::STAT_W-1:0]  o_status
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_longest_gap) && $stable(o_status))
        else $error("result beat changed while stalled");

    // one item at a time: the input closes right after a beat is taken
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in flight");

    // a result cannot appear the cycle after an input beat was taken
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared without processing time");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // configuration is always open
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind longest_gap_after_point_insert_core lgap_checker u_lgap_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_longest_gap (o_longest_gap),
    .o_status      (o_status)
);

@@ tb/tb_longest_gap_after_point_insert_core.sv @@
// ----------------------------------------------------------------------------
// tb_longest_gap_after_point_insert_core: self-checking bench for the core
// Drives positions through the valid/ready input channel and rewrites the
// line length between phases. A small scoreboard keeps its own sorted copy
// of the cut points, predicts longest gap and status for every accepted
// position, and compares each result beat in order. The run covers the
// reset, zero, one and all-ones lengths, repeats, out-of-range positions,
// a full table and a length that shrinks below stored points. It also
// covers random idling on both sides and a long receiver hold that backs
// up the input.
// ----------------------------------------------------------------------------
module tb_longest_gap_after_point_insert_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lgap_pkg::*;

    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int RECV_HOLD_CYCLES = 2000;
    localparam int TAIL_CYCLES     = 600;

    // expected beat on the result channel
    typedef struct packed {
        logic [DATA_W-1:0] gap;
        logic [STAT_W-1:0] status;
    } t_gap_result;

    // sorted point table, line length and queue of expected results
    class t_gap_scoreboard;
        logic [DATA_W-1:0] points[$];
        logic [DATA_W-1:0] line_length;
        t_gap_result       expected_q[$];
        int                mismatches;
        int                results_checked;
        int                length_writes;
        int                status_seen[4];

        function new();
            line_length = '1;
        endfunction

        function void set_length(input logic [DATA_W-1:0] len);
            line_length = len;
            length_writes++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [DATA_W-1:0] stored_point();
            if (points.size() == 0) return 1;
            return points[$urandom_range(points.size() - 1)];
        endfunction

        // rescan with both fixed ends; points not beyond the previous one add nothing
        function logic [DATA_W-1:0] longest_gap();
            logic [DATA_W-1:0] best;
            logic [DATA_W-1:0] prev;
            best = '0;
            prev = '0;
            foreach (points[i]) begin
                if (points[i] > prev) begin
                    if (points[i] - prev > best) best = points[i] - prev;
                    prev = points[i];
                end
            end
            if (line_length > prev && line_length - prev > best) best = line_length - prev;
            return best;
        endfunction

        // predict the result of one accepted position beat
        function void note_position(input logic [DATA_W-1:0] pos);
            t_gap_result res;
            int          slot;
            slot = 0;
            if (pos == 0 || pos >= line_length) begin
                res.status = ST_OUT_RANGE;
            end else if (points.size() >= MAX_POINTS) begin
                res.status = ST_FULL;
            end else begin
                while (slot < points.size() && points[slot] <= pos) slot++;
                points.insert(slot, pos);
                res.status = ST_INSERTED;
            end
            res.gap = longest_gap();
            status_seen[res.status]++;
            expected_q.push_back(res);
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        // compare one result beat against the oldest expectation
        task check_result(input logic [DATA_W-1:0] gap, input logic [STAT_W-1:0] status);
            t_gap_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat with nothing pending: gap %0d status %0d",
                                 gap, status));
                return;
            end
            want = expected_q.pop_front();
            results_checked++;
            if (gap !== want.gap)
                report($sformatf("result %0d longest_gap %0d, expected %0d",
                                 results_checked, gap, want.gap));
            if (status !== want.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 results_checked, status, want.status));
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [DATA_W-1:0] i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [DATA_W-1:0] i_position;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DATA_W-1:0] o_longest_gap;
    logic [STAT_W-1:0] o_status;

    t_gap_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count   = 0;

    longest_gap_after_point_insert_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_longest_gap (o_longest_gap),
        .o_status      (o_status)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_served != hold_request) begin
            hold_served = hold_request;
            hold_left   = RECV_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_longest_gap, o_status);
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results pending",
                 cycle_count, sb.pending());
        $display("[longest_gap_after_point_insert_core] ERROR");
        $finish;
    end

    // one position beat; called and returns at a falling edge
    task automatic push_position(input logic [DATA_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_position <= pos;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_position(pos);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // length write while the core is idle
    task automatic write_length(input logic [DATA_W-1:0] len);
        wait_drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_length(len);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly in-range points, some repeats, the rest zero, too far or any value
    function automatic logic [DATA_W-1:0] pick_position(input logic [DATA_W-1:0] len);
        int r;
        r = $urandom_range(99);
        if (r < 70 && len > 1) return $urandom_range(len - 1, 1);
        if (r < 80) return sb.stored_point();
        if (r < 85) return '0;
        if (r < 92) return r[0] ? len : $urandom_range(32'hFFFF_FFFF, len);
        return $urandom();
    endfunction

    task automatic run_random(input int count, input logic [DATA_W-1:0] len,
                              input int sidle, input int ridle);
        write_length(len);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        repeat (count) push_position(pick_position(len));
        i_in_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_position  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset length: both ends rejected, extremes inserted, a repeat
        push_position(32'd0);
        push_position(32'hFFFF_FFFF);
        push_position(32'd1);
        push_position(32'hFFFF_FFFE);
        push_position(32'h8000_0000);
        push_position(32'h8000_0000);
        i_in_valid <= 1'b0;

        // zero length rejects everything
        write_length(32'd0);
        push_position(32'd5);
        push_position(32'd0);
        i_in_valid <= 1'b0;

        // length one leaves no valid position
        write_length(32'd1);
        push_position(32'd1);
        push_position(32'd0);
        i_in_valid <= 1'b0;

        // shorter length below stored points
        write_length(32'd1000);
        push_position(32'd999);
        push_position(32'd500);
        push_position(32'd1000);
        push_position(32'd1);
        push_position(32'hFFFF_FFFF);

        // long receiver hold while positions keep coming
        hold_request++;
        repeat (6) push_position($urandom_range(999, 1));
        i_in_valid <= 1'b0;

        // sender pauses until every result is back
        wait_drain();

        run_random(150, 32'd100000, 32, 54);
        run_random(500, 32'hFFFF_FFFF, 54, 32);
        run_random(500, 32'd300, 0, 0);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d results: %0d inserted, %0d dropped on a full table, %0d %s",
                 sb.results_checked, sb.status_seen[ST_INSERTED], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_OUT_RANGE], "out of range");
        $display("line length rewritten %0d times (0, 1 and all ones among them), %0d %s",
                 sb.length_writes, sb.points.size(), "points held");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[longest_gap_after_point_insert_core] OK");
        end else begin
            $display("[longest_gap_after_point_insert_core] ERROR");
        end
        $finish;
    end

endmodule
